>>> rtl/apogee_detector_macros.svh
// ----------------------------------------------------------------------------
// apogee detector assertion macros
// shared property shorthands, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef APOGEE_DETECTOR_MACROS_SVH
`define APOGEE_DETECTOR_MACROS_SVH

// same-cycle implication
`define APG_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("apogee detector check failed");

// next-cycle implication
`define APG_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("apogee detector check failed");

`endif

>>> rtl/apg_pkg.sv
// ----------------------------------------------------------------------------
// apogee detector package
// field widths, register indexes and reset values
// ----------------------------------------------------------------------------
package apg_pkg;

	localparam int ALT_W     = 24;
	localparam int TS_W      = 32;
	localparam int REG_W     = 17;
	localparam int CNT_W     = 8;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_COUNT   = 2'd2;

	// register reset values
	localparam logic [REG_W-1:0] MAX_VELOCITY_RST   = 17'd35000;
	localparam logic [REG_W-1:0] DROP_THRESHOLD_RST = 17'd200;
	localparam logic [CNT_W-1:0] DETECT_COUNT_RST   = 8'd5;

	// ms to s scale on the altitude side of the rate gate
	localparam int                VEL_SCALE_W = 10;
	localparam logic [VEL_SCALE_W-1:0] VEL_SCALE = 10'd1000;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

>>> rtl/apogee_detector.sv
// ----------------------------------------------------------------------------
// apogee detector
// tracks peak altitude over timestamped samples and flags apogee
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carry one sample (altitude in cm, signed,
//   timestamp in ms, wrapping). output channel: out_valid/out_ready carry one
//   result per sample (apogee flag, peak altitude, drop count).
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; index 0 max_velocity, 1 drop_threshold, 2 detect_count, others
//   are dropped. write registers only while no sample is in flight.
// pipeline
//   a sample is registered in the input stage at acceptance and evaluated
//   against the tracking state there; its result loads the output register
//   when the input stage advances, which a stalled output can hold off. one
//   sample per cycle is sustained while out_ready is high; the tracking state
//   is updated in the same cycle that the result register loads, so
//   back-to-back samples see each other's state.
// reset
//   arst_n clears the pipeline valids, the tracking state and restores the
//   register defaults.
// stall
//   while out_ready is low the result holds, one more sample may wait in the
//   input stage, and then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module apogee_detector
	import apg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// sample channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [ALT_W-1:0] altitude,
	input  logic [TS_W-1:0]         timestamp,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    apogee,
	output logic signed [ALT_W-1:0] peak_altitude,
	output logic [CNT_W-1:0]        drop_count,
	// config channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]        cfg_data
);

	localparam int DIFF_W = ALT_W + 1;
	localparam int LHS_W  = DIFF_W + VEL_SCALE_W;
	localparam int RHS_W  = REG_W + TS_W;

	// config registers
	logic [REG_W-1:0] max_velocity_q;
	logic [REG_W-1:0] drop_threshold_q;
	logic [CNT_W-1:0] detect_count_q;

	// input stage
	logic                    valid_s1;
	logic signed [ALT_W-1:0] alt_s1;
	logic [TS_W-1:0]         ts_s1;

	// tracking state
	logic                    started_q;
	logic [TS_W-1:0]         last_time_q;
	logic signed [ALT_W-1:0] prev_alt_q;
	logic signed [ALT_W-1:0] peak_alt_q;
	logic [CNT_W-1:0]        below_cnt_q;

	// next state
	logic                    started_nxt;
	logic [TS_W-1:0]         last_time_nxt;
	logic signed [ALT_W-1:0] prev_alt_nxt;
	logic signed [ALT_W-1:0] peak_alt_nxt;
	logic [CNT_W-1:0]        below_cnt_nxt;
	logic                    fire;

	// result register
	logic                    out_valid_q;
	logic                    apogee_q;
	logic signed [ALT_W-1:0] peak_q;
	logic [CNT_W-1:0]        cnt_q;

	// datapath
	logic [TS_W-1:0]          dt;
	logic signed [DIFF_W-1:0] alt_diff;
	logic [DIFF_W-1:0]        alt_mag;
	logic [LHS_W-1:0]         lhs;
	logic [RHS_W-1:0]         rhs;
	logic                     gate_pass;
	logic                     rise;
	logic signed [DIFF_W-1:0] peak_drop;
	logic                     drop_big;
	logic [CNT_W-1:0]         cnt_inc;

	logic adv_s1;

	// ---------------- handshake ----------------
	// stage 1 moves when the result register is empty or being drained
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// ---------------- config registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_velocity_q   <= MAX_VELOCITY_RST;
			drop_threshold_q <= DROP_THRESHOLD_RST;
			detect_count_q   <= DETECT_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_VELOCITY:   max_velocity_q   <= cfg_data;
				REG_DROP_THRESHOLD: drop_threshold_q <= cfg_data;
				REG_DETECT_COUNT:   detect_count_q   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			alt_s1 <= altitude;
			ts_s1  <= timestamp;
		end
	end

	// ---------------- rate gate ----------------
	// elapsed time wraps modulo 2^32
	assign dt       = ts_s1 - last_time_q;
	assign alt_diff = DIFF_W'(alt_s1) - DIFF_W'(prev_alt_q);
	// a 24-bit difference never reaches the negative end of 25 bits
	assign alt_mag  = alt_diff[DIFF_W-1] ? DIFF_W'(-alt_diff) : DIFF_W'(alt_diff);
	// |dalt| * 1000 < vmax * dt, exact in integers
	assign lhs       = LHS_W'(alt_mag) * LHS_W'(VEL_SCALE);
	assign rhs       = RHS_W'(max_velocity_q) * RHS_W'(dt);
	assign gate_pass = RHS_W'(lhs) < rhs;

	// ---------------- peak and drop tracking ----------------
	assign rise      = alt_s1 > peak_alt_q;
	// non-negative whenever the sample is not a new peak
	assign peak_drop = DIFF_W'(peak_alt_q) - DIFF_W'(alt_s1);
	assign drop_big  = DIFF_W'(peak_drop) >= DIFF_W'(drop_threshold_q);
	assign cnt_inc   = (below_cnt_q == CNT_MAX) ? below_cnt_q : below_cnt_q + 1'b1;

	always_comb begin
		started_nxt   = started_q;
		last_time_nxt = last_time_q;
		prev_alt_nxt  = prev_alt_q;
		peak_alt_nxt  = peak_alt_q;
		below_cnt_nxt = below_cnt_q;
		fire          = 1'b0;
		if (!started_q) begin
			// first sample only seeds the state, count is kept
			started_nxt   = 1'b1;
			last_time_nxt = ts_s1;
			prev_alt_nxt  = alt_s1;
			peak_alt_nxt  = alt_s1;
		end else if (dt != '0) begin
			if (gate_pass) begin
				if (rise) begin
					peak_alt_nxt  = alt_s1;
					below_cnt_nxt = '0;
				end else if (drop_big) begin
					below_cnt_nxt = cnt_inc;
				end else begin
					below_cnt_nxt = '0;
				end
				fire = below_cnt_nxt >= detect_count_q;
			end
			// on apogee the previous sample is held
			if (!fire) begin
				prev_alt_nxt  = alt_s1;
				last_time_nxt = ts_s1;
			end
		end
		// zero elapsed time: sample ignored, state unchanged
	end

	// state moves with the item it belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			last_time_q <= '0;
			prev_alt_q  <= '0;
			peak_alt_q  <= '0;
			below_cnt_q <= '0;
		end else if (adv_s1) begin
			started_q   <= started_nxt;
			last_time_q <= last_time_nxt;
			prev_alt_q  <= prev_alt_nxt;
			peak_alt_q  <= peak_alt_nxt;
			below_cnt_q <= below_cnt_nxt;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			apogee_q <= fire;
			peak_q   <= peak_alt_nxt;
			cnt_q    <= below_cnt_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign apogee        = apogee_q;
	assign peak_altitude = peak_q;
	assign drop_count    = cnt_q;

endmodule

>>> rtl/apg_checker.sv
// ----------------------------------------------------------------------------
// apogee detector checker
// port-level checks on the result, input and config channels and the drop count sequence
// ----------------------------------------------------------------------------
`include "apogee_detector_macros.svh"

module apg_checker
	import apg_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    apogee,
	input logic signed [ALT_W-1:0] peak_altitude,
	input logic [CNT_W-1:0]        drop_count,
	input logic                    cfg_valid,
	input logic                    cfg_ready
);

	// drop count of the last delivered result
	logic [CNT_W-1:0] last_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cnt_q <= '0;
		end else if (out_valid && out_ready) begin
			last_cnt_q <= drop_count;
		end
	end

	// a stalled result transaction holds its payload
	`APG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(apogee) && $stable(peak_altitude) && $stable(drop_count))

	// with the result register empty the input stage can always take a sample
	`APG_ASSERT_SAME(a_in_ready_free, !out_valid, in_ready)

	// the count only holds, steps by one or clears between results
	`APG_ASSERT_SAME(a_cnt_step, out_valid && out_ready,
		drop_count == last_cnt_q || drop_count == last_cnt_q + 8'd1 || drop_count == '0)

	// config port never back-pressures
	`APG_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind apogee_detector apg_checker u_apg_checker (.*);
